### rtl/ppcr_pkg.sv
package ppcr_pkg;

    localparam int NRM_BITS   = 30;
    localparam int RATIO_BITS = 16;

    localparam int S_TDATA_W = 288;
    localparam int M_TDATA_W = 256;

    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 2;

    // square root: one result bit per stage, radicand two bits per stage
    localparam int SQ_STAGES = 32;
    localparam int RAD_W     = 2 * SQ_STAGES;
    localparam int REM_W     = SQ_STAGES + 2;

    // divider: quotient of a * 2^30 / d with a <= d, one bit per stage
    localparam int DIV_STAGES = NRM_BITS + 1;

    localparam logic [16:0] RATIO_ONE = 17'h1_0000;
    localparam logic [30:0] NRM_ONE   = 31'h4000_0000;

    localparam logic [CFG_W-1:0] SLOP_RST       = 17'd655;
    localparam logic [CFG_W-1:0] CORR_FRAC_RST  = 17'd52429;
    localparam logic [CFG_W-1:0] PEN_CLAMP_RST  = 17'd32768;
    localparam logic [CFG_W-1:0] CORR_CLAMP_RST = 17'd13107;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SLOP,
        REG_CORR_FRAC,
        REG_PEN_CLAMP,
        REG_CORR_CLAMP
    } cfg_reg_t;

    typedef struct packed {
        logic [CFG_W-1:0] slop;
        logic [CFG_W-1:0] corr_frac;
        logic [CFG_W-1:0] pen_ratio;
        logic [CFG_W-1:0] corr_ratio;
    } cfg_t;

    typedef struct packed {
        logic               vld;
        logic               dx_neg;
        logic               dy_neg;
        logic [31:0]        adx;
        logic [31:0]        ady;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic [31:0]        rsum;
        logic [30:0]        ima;
        logic [30:0]        imb;
        logic [31:0]        isum;
        logic [16:0]        e;
        logic               imp_on;
    } side1_t;

    typedef struct packed {
        logic               vld;
        logic               dx_neg;
        logic               dy_neg;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic [31:0]        rsum;
        logic [31:0]        distance;
        logic               isum_zero;
        logic [16:0]        e;
        logic               imp_on;
    } side2_t;

    typedef struct packed {
        logic               vld;
        logic               contact;
        logic signed [31:0] dvel_a_x;
        logic signed [31:0] dvel_a_y;
        logic signed [31:0] dvel_b_x;
        logic signed [31:0] dvel_b_y;
        logic signed [31:0] dpos_a_x;
        logic signed [31:0] dpos_a_y;
        logic signed [31:0] dpos_b_x;
        logic signed [31:0] dpos_b_y;
    } result_t;

endpackage

### rtl/particle_pair_collision_response_unit.sv
// Collision response for one pair of 2D circles per word, Q16.16 fixed point.
// Input channel s_*: one candidate pair per word (offset and relative velocity
// of B to A, radii, inverse masses, restitutions, impulse enable). Result
// channel m_*: one word per pair, contact flag on m_tuser and the velocity and
// position changes for both bodies on m_tdata.
// The four tuning registers are set through cfg_we / cfg_index / cfg_data,
// one register per cycle. The user must change them only while no pair is in
// flight; the block does not enforce this. Stages: input and squaring (2), a
// 32-stage square root with one root bit per stage, 31-stage dividers for the
// unit normal and the mass split with one quotient bit per stage, and 8 stages
// of dot product, clamps, impulse and correction products and saturation.
// Throughput is one pair per cycle. All stages advance together; when the
// receiver holds m_tready low with a word waiting, the whole pipeline holds
// and s_tready drops in the same cycle, so nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties the pipeline and loads the
// register defaults: slop 655, correction fraction 52429, penetration clamp
// 32768, correction clamp 13107.
module particle_pair_collision_response_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // delta_x, delta_y, rel_vel_x, rel_vel_y, radius_a, radius_b,
    // inv_mass_a, inv_mass_b, restitution_a, restitution_b, apply_impulse
    input  logic [ppcr_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // dvel_a_x, dvel_a_y, dvel_b_x, dvel_b_y, dpos_a_x, dpos_a_y, dpos_b_x, dpos_b_y
    output logic [ppcr_pkg::M_TDATA_W-1:0]   m_tdata,
    // contact
    output logic                             m_tuser,
    input  logic                             cfg_we,
    input  logic [ppcr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ppcr_pkg::CFG_W-1:0]       cfg_data
);
    import ppcr_pkg::*;

    logic    en;
    result_t res;
    cfg_t    cfg_reg;

    assign en       = !res.vld || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.slop       <= SLOP_RST;
            cfg_reg.corr_frac  <= CORR_FRAC_RST;
            cfg_reg.pen_ratio  <= PEN_CLAMP_RST;
            cfg_reg.corr_ratio <= CORR_CLAMP_RST;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_SLOP:       cfg_reg.slop       <= cfg_data;
                REG_CORR_FRAC:  cfg_reg.corr_frac  <= cfg_data;
                REG_PEN_CLAMP:  cfg_reg.pen_ratio  <= cfg_data;
                REG_CORR_CLAMP: cfg_reg.corr_ratio <= cfg_data;
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // input fields
    logic signed [31:0] in_dx, in_dy, in_vx, in_vy;
    logic [30:0]        in_ra, in_rb, in_ima, in_imb;
    logic [16:0]        in_ea, in_eb, e_min;
    logic [31:0]        adx_in, ady_in;
    logic [63:0]        sqx_next, sqy_next;
    side1_t             p0_side_next;

    assign in_dx  = s_tdata[31:0];
    assign in_dy  = s_tdata[63:32];
    assign in_vx  = s_tdata[95:64];
    assign in_vy  = s_tdata[127:96];
    assign in_ra  = s_tdata[158:128];
    assign in_rb  = s_tdata[189:159];
    assign in_ima = s_tdata[220:190];
    assign in_imb = s_tdata[251:221];
    assign in_ea  = s_tdata[268:252];
    assign in_eb  = s_tdata[285:269];

    assign adx_in   = in_dx[31] ? (32'd0 - in_dx) : in_dx;
    assign ady_in   = in_dy[31] ? (32'd0 - in_dy) : in_dy;
    assign sqx_next = adx_in * adx_in;
    assign sqy_next = ady_in * ady_in;
    assign e_min    = (in_ea < in_eb) ? in_ea : in_eb;

    always_comb begin
        p0_side_next.vld    = s_tvalid;
        p0_side_next.dx_neg = in_dx[31];
        p0_side_next.dy_neg = in_dy[31];
        p0_side_next.adx    = adx_in;
        p0_side_next.ady    = ady_in;
        p0_side_next.vx     = in_vx;
        p0_side_next.vy     = in_vy;
        p0_side_next.rsum   = {1'b0, in_ra} + {1'b0, in_rb};
        p0_side_next.ima    = in_ima;
        p0_side_next.imb    = in_imb;
        p0_side_next.isum   = {1'b0, in_ima} + {1'b0, in_imb};
        p0_side_next.e      = (e_min > RATIO_ONE) ? RATIO_ONE : e_min;
        p0_side_next.imp_on = s_tdata[286];
    end

    side1_t      p0_side_reg, p1_side_reg;
    logic [63:0] sqx_reg, sqy_reg, sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_side_reg <= '0;
            p1_side_reg <= '0;
        end else if (en) begin
            p0_side_reg <= p0_side_next;
            p1_side_reg <= p0_side_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sqx_reg <= sqx_next;
            sqy_reg <= sqy_next;
            sum_reg <= sqx_reg + sqy_reg;
        end
    end

    logic [SQ_STAGES-1:0] sq_root;

    ppcr_sqrt u_sqrt (
        .aclk     (aclk),
        .en       (en),
        .radicand (sum_reg),
        .root     (sq_root)
    );

    side1_t dl1_reg [SQ_STAGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SQ_STAGES; i++) begin
                dl1_reg[i] <= '0;
            end
        end else if (en) begin
            dl1_reg[0] <= p1_side_reg;
            for (int i = 1; i < SQ_STAGES; i++) begin
                dl1_reg[i] <= dl1_reg[i-1];
            end
        end
    end

    side1_t s1;
    side2_t s2_next;

    assign s1 = dl1_reg[SQ_STAGES-1];

    always_comb begin
        s2_next.vld       = s1.vld;
        s2_next.dx_neg    = s1.dx_neg;
        s2_next.dy_neg    = s1.dy_neg;
        s2_next.vx        = s1.vx;
        s2_next.vy        = s1.vy;
        s2_next.rsum      = s1.rsum;
        s2_next.distance  = sq_root;
        s2_next.isum_zero = (s1.isum == '0);
        s2_next.e         = s1.e;
        s2_next.imp_on    = s1.imp_on;
    end

    logic [DIV_STAGES-1:0] mx, my, fa, fb;

    ppcr_div u_div_nx (.aclk(aclk), .en(en), .num(s1.adx), .den(sq_root), .quo(mx));
    ppcr_div u_div_ny (.aclk(aclk), .en(en), .num(s1.ady), .den(sq_root), .quo(my));
    ppcr_div u_div_fa (.aclk(aclk), .en(en), .num({1'b0, s1.ima}), .den(s1.isum), .quo(fa));
    ppcr_div u_div_fb (.aclk(aclk), .en(en), .num({1'b0, s1.imb}), .den(s1.isum), .quo(fb));

    side2_t dl2_reg [DIV_STAGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIV_STAGES; i++) begin
                dl2_reg[i] <= '0;
            end
        end else if (en) begin
            dl2_reg[0] <= s2_next;
            for (int i = 1; i < DIV_STAGES; i++) begin
                dl2_reg[i] <= dl2_reg[i-1];
            end
        end
    end

    ppcr_resp u_resp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .cfg     (cfg_reg),
        .side    (dl2_reg[DIV_STAGES-1]),
        .mx      (mx),
        .my      (my),
        .fa      (fa),
        .fb      (fb),
        .res     (res)
    );

    assign m_tvalid = res.vld;
    assign m_tuser  = res.contact;
    assign m_tdata  = {res.dpos_b_y, res.dpos_b_x, res.dpos_a_y, res.dpos_a_x,
                       res.dvel_b_y, res.dvel_b_x, res.dvel_a_y, res.dvel_a_x};

`ifndef SYNTHESIS
    a_no_contact_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("change fields nonzero without contact");

    a_dpos_opposite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(res.dpos_a_x != '0 && res.dpos_b_x != '0 &&
                       res.dpos_a_x[31] == res.dpos_b_x[31]))
        else $error("position corrections of A and B point the same way");

    a_dvel_opposite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(res.dvel_a_y != '0 && res.dvel_b_y != '0 &&
                       res.dvel_a_y[31] == res.dvel_b_y[31]))
        else $error("velocity changes of A and B point the same way");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");
`endif

endmodule

### rtl/ppcr_sqrt.sv
module ppcr_sqrt (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [ppcr_pkg::RAD_W-1:0]    radicand,
    output logic [ppcr_pkg::SQ_STAGES-1:0] root
);
    import ppcr_pkg::*;

    logic [REM_W-1:0]     rem_reg  [SQ_STAGES-1];
    logic [SQ_STAGES-1:0] root_reg [SQ_STAGES];
    logic [RAD_W-1:0]     rad_reg  [SQ_STAGES-1];

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
        logic [REM_W-1:0]     rem_prev;
        logic [SQ_STAGES-1:0] root_prev;
        logic [RAD_W-1:0]     rad_prev;
        logic [REM_W+1:0]     rem_sh;
        logic [REM_W+1:0]     trial;
        logic                 ge;
        logic [SQ_STAGES-1:0] root_next;

        if (k == 0) begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign rad_prev  = radicand;
        end else begin : g_next
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign rad_prev  = rad_reg[k-1];
        end

        // bring down the next two radicand bits, try (2*root)*2 + 1
        assign rem_sh    = {rem_prev, rad_prev[RAD_W-1-2*k -: 2]};
        assign trial     = {2'b00, root_prev, 2'b01};
        assign ge        = (rem_sh >= trial);
        assign root_next = {root_prev[SQ_STAGES-2:0], ge};

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[k] <= root_next;
            end
        end

        if (k < SQ_STAGES - 1) begin : g_carry
            logic [REM_W+1:0] rem_diff;
            assign rem_diff = ge ? (rem_sh - trial) : rem_sh;
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= rem_diff[REM_W-1:0];
                    rad_reg[k] <= rad_prev;
                end
            end
        end
    end

    assign root = root_reg[SQ_STAGES-1];

endmodule

### rtl/ppcr_div.sv
module ppcr_div (
    input  logic                            aclk,
    input  logic                            en,
    input  logic [31:0]                     num,
    input  logic [31:0]                     den,
    output logic [ppcr_pkg::DIV_STAGES-1:0] quo
);
    import ppcr_pkg::*;

    logic [31:0]           rem_reg [DIV_STAGES-1];
    logic [31:0]           den_reg [DIV_STAGES-1];
    logic [DIV_STAGES-1:0] q_reg   [DIV_STAGES];

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
        logic [32:0]           rem_prev;
        logic [31:0]           den_prev;
        logic [DIV_STAGES-1:0] q_prev;
        logic                  ge;

        if (j == 0) begin : g_first
            // num <= den, so the top quotient bit is the only one above the point
            assign rem_prev = {1'b0, num};
            assign den_prev = den;
            assign q_prev   = '0;
        end else begin : g_next
            assign rem_prev = {rem_reg[j-1], 1'b0};
            assign den_prev = den_reg[j-1];
            assign q_prev   = q_reg[j-1];
        end

        assign ge = (rem_prev >= {1'b0, den_prev});

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[j] <= {q_prev[DIV_STAGES-2:0], ge};
            end
        end

        if (j < DIV_STAGES - 1) begin : g_carry
            logic [32:0] rem_next;
            assign rem_next = ge ? (rem_prev - {1'b0, den_prev}) : rem_prev;
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[j] <= rem_next[31:0];
                    den_reg[j] <= den_prev;
                end
            end
        end
    end

    assign quo = q_reg[DIV_STAGES-1];

endmodule

### rtl/ppcr_resp.sv
module ppcr_resp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  ppcr_pkg::cfg_t                   cfg,
    input  ppcr_pkg::side2_t                 side,
    input  logic [ppcr_pkg::DIV_STAGES-1:0]  mx,
    input  logic [ppcr_pkg::DIV_STAGES-1:0]  my,
    input  logic [ppcr_pkg::DIV_STAGES-1:0]  fa,
    input  logic [ppcr_pkg::DIV_STAGES-1:0]  fb,
    output ppcr_pkg::result_t                res
);
    import ppcr_pkg::*;

    function automatic logic [31:0] sat_out(input logic [33:0] mag, input logic neg);
        logic [31:0] r;
        if (neg && mag != '0) begin
            r = (mag >= 34'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - mag[31:0]);
        end else begin
            r = (mag > 34'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        end
        return r;
    endfunction

    // valid chain, stages 1 to 7 (stage 8 is the result register)
    logic [6:0] vld_reg;

    // flags that ride along
    logic [6:0] contact_reg;
    logic [6:0] mass_ok_reg;
    logic [6:0] imp_on_reg;
    logic [4:0] approach_reg;   // stages 3 to 7
    logic [6:0] sx_reg;
    logic [6:0] sy_reg;

    logic [30:0] nmx_reg [6];
    logic [30:0] nmy_reg [6];
    logic [30:0] fa_reg  [5];
    logic [30:0] fb_reg  [5];
    logic [16:0] e_reg   [3];

    // stage 1
    logic signed [63:0] px_reg, py_reg;
    logic [31:0]        pen_reg;
    logic [48:0]        plim_reg, clim_reg;
    // stage 2
    logic signed [63:0] vn_reg;
    logic [31:0]        pen_c_reg;
    logic [32:0]        clim_q2_reg;
    // stage 3
    logic [32:0]        vq_reg;
    logic [31:0]        excess_reg;
    logic [32:0]        clim_q3_reg;
    // stage 4
    logic [50:0]        imp_pre_reg;
    logic [48:0]        corr_pre_reg;
    logic [32:0]        clim_q4_reg;
    // stage 5
    logic [33:0]        imp_reg;
    logic [32:0]        corr_reg;
    // stage 6
    logic [33:0]        sa_reg, sb_reg;
    logic [32:0]        ca_reg, cb_reg;
    // stage 7
    logic [33:0]        mvax_reg, mvay_reg, mvbx_reg, mvby_reg;
    logic [33:0]        mpax_reg, mpay_reg, mpbx_reg, mpby_reg;

    // stage 1 logic
    logic               dist_zero;
    logic [30:0]        nmx_next, nmy_next;
    logic signed [63:0] px_next, py_next;
    logic [48:0]        plim_next, clim_next;

    assign dist_zero = (side.distance == '0);
    assign nmx_next  = dist_zero ? NRM_ONE : mx;
    assign nmy_next  = dist_zero ? '0 : my;
    assign px_next   = side.vx * $signed({1'b0, nmx_next});
    assign py_next   = side.vy * $signed({1'b0, nmy_next});
    assign plim_next = side.rsum * cfg.pen_ratio;
    assign clim_next = side.rsum * cfg.corr_ratio;

    // stage 2 logic
    logic signed [63:0] vn_next;
    logic [31:0]        pen_c_next;

    assign vn_next    = (sx_reg[0] ? -px_reg : px_reg) + (sy_reg[0] ? -py_reg : py_reg);
    assign pen_c_next = ({1'b0, pen_reg} > plim_reg[48:16]) ? plim_reg[47:16] : pen_reg;

    // stage 3 logic: turn the normal against the motion
    logic        flip;
    logic [63:0] vmag;
    logic [31:0] excess_next;

    assign flip        = (vn_reg > 0);
    assign vmag        = vn_reg[63] ? (64'd0 - vn_reg) : vn_reg;
    assign excess_next = (pen_c_reg > {15'd0, cfg.slop}) ? (pen_c_reg - {15'd0, cfg.slop}) : '0;

    // stage 4 logic
    logic [50:0] imp_pre_next;
    logic [48:0] corr_pre_next;

    assign imp_pre_next  = ({1'b0, e_reg[2]} + {1'b0, RATIO_ONE}) * vq_reg;
    assign corr_pre_next = excess_reg * cfg.corr_frac;

    // stage 5 logic
    logic [32:0] corr_q;

    assign corr_q = corr_pre_reg[48:16];

    // stage 6 logic
    logic [64:0] sa_prod, sb_prod;
    logic [63:0] ca_prod, cb_prod;

    assign sa_prod = imp_reg * fa_reg[4];
    assign sb_prod = imp_reg * fb_reg[4];
    assign ca_prod = corr_reg * fa_reg[4];
    assign cb_prod = corr_reg * fb_reg[4];

    // stage 7 logic
    logic [64:0] mvax_p, mvay_p, mvbx_p, mvby_p;
    logic [63:0] mpax_p, mpay_p, mpbx_p, mpby_p;

    assign mvax_p = sa_reg * nmx_reg[5];
    assign mvay_p = sa_reg * nmy_reg[5];
    assign mvbx_p = sb_reg * nmx_reg[5];
    assign mvby_p = sb_reg * nmy_reg[5];
    assign mpax_p = ca_reg * nmx_reg[5];
    assign mpay_p = ca_reg * nmy_reg[5];
    assign mpbx_p = cb_reg * nmx_reg[5];
    assign mpby_p = cb_reg * nmy_reg[5];

    // stage 8 logic
    logic    dv_ok, dp_ok;
    result_t res_next;

    assign dv_ok = contact_reg[6] & mass_ok_reg[6] & imp_on_reg[6] & approach_reg[4];
    assign dp_ok = contact_reg[6] & mass_ok_reg[6];

    always_comb begin
        res_next          = '0;
        res_next.vld      = vld_reg[6];
        res_next.contact  = contact_reg[6];
        if (dv_ok) begin
            res_next.dvel_a_x = sat_out(mvax_reg, !sx_reg[6]);
            res_next.dvel_a_y = sat_out(mvay_reg, !sy_reg[6]);
            res_next.dvel_b_x = sat_out(mvbx_reg, sx_reg[6]);
            res_next.dvel_b_y = sat_out(mvby_reg, sy_reg[6]);
        end
        if (dp_ok) begin
            res_next.dpos_a_x = sat_out(mpax_reg, !sx_reg[6]);
            res_next.dpos_a_y = sat_out(mpay_reg, !sy_reg[6]);
            res_next.dpos_b_x = sat_out(mpbx_reg, sx_reg[6]);
            res_next.dpos_b_y = sat_out(mpby_reg, sy_reg[6]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            res.vld <= 1'b0;
        end else if (en) begin
            vld_reg <= {vld_reg[5:0], side.vld};
            res.vld <= res_next.vld;

            contact_reg <= {contact_reg[5:0], (side.rsum > side.distance)};
            mass_ok_reg <= {mass_ok_reg[5:0], !side.isum_zero};
            imp_on_reg  <= {imp_on_reg[5:0], side.imp_on};
            sx_reg      <= {sx_reg[5:2], sx_reg[1] ^ flip, sx_reg[0],
                            side.dx_neg & !dist_zero};
            sy_reg      <= {sy_reg[5:2], sy_reg[1] ^ flip, sy_reg[0],
                            side.dy_neg & !dist_zero};
            approach_reg <= {approach_reg[3:0], (vn_reg != '0)};

            nmx_reg[0] <= nmx_next;
            nmy_reg[0] <= nmy_next;
            for (int i = 1; i < 6; i++) begin
                nmx_reg[i] <= nmx_reg[i-1];
                nmy_reg[i] <= nmy_reg[i-1];
            end
            fa_reg[0] <= fa;
            fb_reg[0] <= fb;
            for (int i = 1; i < 5; i++) begin
                fa_reg[i] <= fa_reg[i-1];
                fb_reg[i] <= fb_reg[i-1];
            end
            e_reg[0] <= side.e;
            e_reg[1] <= e_reg[0];
            e_reg[2] <= e_reg[1];

            px_reg   <= px_next;
            py_reg   <= py_next;
            pen_reg  <= side.rsum - side.distance;
            plim_reg <= plim_next;
            clim_reg <= clim_next;

            vn_reg      <= vn_next;
            pen_c_reg   <= pen_c_next;
            clim_q2_reg <= clim_reg[48:16];

            vq_reg      <= vmag[62:30];
            excess_reg  <= excess_next;
            clim_q3_reg <= clim_q2_reg;

            imp_pre_reg  <= imp_pre_next;
            corr_pre_reg <= corr_pre_next;
            clim_q4_reg  <= clim_q3_reg;

            imp_reg  <= imp_pre_reg[49:16];
            corr_reg <= (corr_q > clim_q4_reg) ? clim_q4_reg : corr_q;

            sa_reg <= sa_prod[63:30];
            sb_reg <= sb_prod[63:30];
            ca_reg <= ca_prod[62:30];
            cb_reg <= cb_prod[62:30];

            mvax_reg <= mvax_p[63:30];
            mvay_reg <= mvay_p[63:30];
            mvbx_reg <= mvbx_p[63:30];
            mvby_reg <= mvby_p[63:30];
            mpax_reg <= {1'b0, mpax_p[62:30]};
            mpay_reg <= {1'b0, mpay_p[62:30]};
            mpbx_reg <= {1'b0, mpbx_p[62:30]};
            mpby_reg <= {1'b0, mpby_p[62:30]};

            res.contact  <= res_next.contact;
            res.dvel_a_x <= res_next.dvel_a_x;
            res.dvel_a_y <= res_next.dvel_a_y;
            res.dvel_b_x <= res_next.dvel_b_x;
            res.dvel_b_y <= res_next.dvel_b_y;
            res.dpos_a_x <= res_next.dpos_a_x;
            res.dpos_a_y <= res_next.dpos_a_y;
            res.dpos_b_x <= res_next.dpos_b_x;
            res.dpos_b_y <= res_next.dpos_b_y;
        end
    end

endmodule
